/* hdl/htar_pkg.sv */
// Package: command, result and slot types shared by the hashed table design.
`default_nettype none
package htar_pkg;

  typedef enum logic [1:0] {
    KIND_STORE  = 2'd0,
    KIND_PROBE  = 2'd1,
    KIND_SEARCH = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    OUT_EMPTY   = 3'd0,
    OUT_REFRESH = 3'd1,
    OUT_STALE   = 3'd2,
    OUT_DEPTH   = 3'd3,
    OUT_REJECT  = 3'd4,
    OUT_NONE    = 3'd5
  } outcome_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_DIV,
    ST_READ,
    ST_CALC,
    ST_EVAL
  } state_e;

  typedef enum logic {
    REG_ENTRIES = 1'b0,
    REG_WEIGHT  = 1'b1
  } reg_idx_e;

  localparam int unsigned KeyW  = 64;
  localparam int unsigned CfgW  = 17;
  localparam int unsigned FLAG_EXACT = 0;

  typedef struct packed {
    kind_e              kind;
    logic [63:0]        key;
    logic signed [15:0] score;
    logic signed [15:0] search_depth;
    logic [1:0]         bound_flag;
    logic [15:0]        best_move;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic signed [15:0] entry_score;
    logic signed [15:0] entry_depth;
    logic [1:0]         entry_flag;
    logic [15:0]        entry_move;
    logic [7:0]         entry_age;
    outcome_e           outcome;
  } res_t;

  typedef struct packed {
    logic signed [15:0] score;
    logic signed [15:0] depth;
    logic [1:0]         flag;
    logic [15:0]        move;
    logic [7:0]         age;
  } slot_t;

endpackage
`default_nettype wire

/* hdl/htar_mod.sv */
// Iterative remainder unit: 64-bit key modulo slot count, one bit per cycle.
`default_nettype none
module htar_mod #(
  parameter int unsigned NW = 17
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [63:0]   dividend_i,
  input  wire logic [NW-1:0] divisor_i,
  output logic               done_o,
  output logic [NW-1:0]      rem_o
);

  localparam int unsigned CW = $clog2(htar_pkg::KeyW);

  logic          run_q, run_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [63:0]   dvd_q, dvd_d;
  logic [NW-1:0] rem_q, rem_d;
  logic [NW-1:0] div_q, div_d;
  logic [NW:0]   trial, diff;

  always_comb begin
    trial  = {rem_q, dvd_q[63]};
    diff   = trial - {1'b0, div_q};
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      dvd_d = dividend_i;
      rem_d = '0;
      div_d = divisor_i;
    end else if (run_q) begin
      // restoring step: remainder stays below the divisor
      rem_d = (trial >= {1'b0, div_q}) ? diff[NW-1:0] : trial[NW-1:0];
      dvd_d = {dvd_q[62:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(htar_pkg::KeyW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

/* hdl/hashed_table_with_age_replacement.sv */
// Top level: direct-mapped result table with depth and age replacement.
//
//  channel   | signals                           | handshake
//  ----------+-----------------------------------+-------------------------------
//  request   | start, busy, req_i                | taken when start && !busy
//  result    | done_o, res_o                     | one-cycle strobe, no stall
//  config    | cfg_we_i, cfg_idx_i, cfg_data_i   | written when cfg_we_i is high
//
// Store/probe: 64 steps and the done strobe of the shared remainder unit, then read,
// multiply and update of the slot in the states ST_READ, ST_CALC and ST_EVAL.
// New search: result in the cycle after the request.
// Clear: walks every slot of the slot memory in turn, writing it to zero.
// After reset the same clearing pass runs, with busy high.
// The receiver cannot stall; one request is in flight at a time.
`default_nettype none
module hashed_table_with_age_replacement #(
  parameter int unsigned TABLE_ENTRIES = 65536
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire htar_pkg::req_t               req_i,
  output logic                              done_o,
  output htar_pkg::res_t                    res_o,
  input  wire logic                         cfg_we_i,
  input  wire logic                         cfg_idx_i,
  input  wire logic [htar_pkg::CfgW-1:0]    cfg_data_i
);

  localparam int unsigned NW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  htar_pkg::state_e state_q, state_d;
  htar_pkg::req_t   req_q, req_d;
  htar_pkg::res_t   res_q, res_d;
  logic             done_q, done_d;
  logic             clr_cmd_q, clr_cmd_d;
  logic [AW-1:0]    clr_cnt_q, clr_cnt_d;
  logic [7:0]       age_q, age_d;
  logic [15:0]      prod_q, prod_d;
  logic [htar_pkg::CfgW-1:0] entries_q;
  logic [7:0]       weight_q;

  logic             accept;
  logic             div_start, div_done;
  logic [NW-1:0]    divisor, rem;
  logic [31:0]      n_wide;

  logic [63:0]            key_mem [TABLE_ENTRIES];
  htar_pkg::slot_t        pay_mem [TABLE_ENTRIES];
  logic [63:0]            rd_key_q;
  htar_pkg::slot_t        rd_pay_q;
  logic                   mem_we;
  logic [AW-1:0]          wr_addr;
  logic [63:0]            wr_key;
  htar_pkg::slot_t        wr_pay;

  logic                   is_empty, is_match;
  logic signed [17:0]     worth;
  logic [7:0]             age_diff;

  assign accept = start && !busy;

  // effective slot count: zero acts as one, clipped to the table size
  always_comb begin
    if (entries_q == '0) begin
      n_wide = 32'd1;
    end else if (32'(entries_q) > 32'(TABLE_ENTRIES)) begin
      n_wide = 32'(TABLE_ENTRIES);
    end else begin
      n_wide = 32'(entries_q);
    end
    divisor = NW'(n_wide);
  end

  assign div_start = accept &&
      (req_i.kind == htar_pkg::KIND_STORE || req_i.kind == htar_pkg::KIND_PROBE);

  htar_mod #(.NW(NW)) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (req_i.key),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .rem_o      (rem)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      htar_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (req_i.kind) inside
            htar_pkg::KIND_STORE, htar_pkg::KIND_PROBE: state_d = htar_pkg::ST_DIV;
            htar_pkg::KIND_CLEAR:                       state_d = htar_pkg::ST_CLEAR;
            default:                                    state_d = htar_pkg::ST_IDLE;
          endcase
        end
      end
      htar_pkg::ST_CLEAR: begin
        if (clr_cnt_q == AW'(TABLE_ENTRIES - 1)) state_d = htar_pkg::ST_IDLE;
      end
      htar_pkg::ST_DIV:  if (div_done) state_d = htar_pkg::ST_READ;
      htar_pkg::ST_READ: state_d = htar_pkg::ST_CALC;
      htar_pkg::ST_CALC: state_d = htar_pkg::ST_EVAL;
      htar_pkg::ST_EVAL: state_d = htar_pkg::ST_IDLE;
      default:           state_d = htar_pkg::ST_IDLE;
    endcase
  end

  assign is_empty = (rd_key_q == '0);
  assign is_match = (rd_key_q == req_q.key);
  assign age_diff = age_q - rd_pay_q.age;
  assign worth    = 18'(rd_pay_q.depth) - $signed({2'b00, prod_q});

  // datapath and outputs
  always_comb begin
    req_d     = req_q;
    res_d     = res_q;
    done_d    = 1'b0;
    clr_cmd_d = clr_cmd_q;
    clr_cnt_d = clr_cnt_q;
    age_d     = age_q;
    prod_d    = prod_q;
    mem_we    = 1'b0;
    wr_addr   = rem[AW-1:0];
    wr_key    = req_q.key;
    wr_pay.score = req_q.score;
    wr_pay.depth = req_q.search_depth;
    wr_pay.flag  = req_q.bound_flag;
    wr_pay.move  = req_q.best_move;
    wr_pay.age   = age_q;

    unique case (state_q)
      htar_pkg::ST_IDLE: begin
        if (accept) begin
          req_d = req_i;
          if (req_i.kind == htar_pkg::KIND_SEARCH) begin
            age_d         = age_q + 8'd1;
            done_d        = 1'b1;
            res_d         = '0;
            res_d.outcome = htar_pkg::OUT_NONE;
          end else if (req_i.kind == htar_pkg::KIND_CLEAR) begin
            clr_cmd_d = 1'b1;
            clr_cnt_d = '0;
            age_d     = 8'd0;
          end
        end
      end
      htar_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        wr_addr   = clr_cnt_q;
        wr_key    = '0;
        wr_pay    = '0;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == AW'(TABLE_ENTRIES - 1)) begin
          clr_cmd_d = 1'b0;
          done_d    = clr_cmd_q;
          res_d         = '0;
          res_d.outcome = htar_pkg::OUT_NONE;
        end
      end
      htar_pkg::ST_CALC: begin
        prod_d = 16'(weight_q) * 16'(age_diff);
      end
      htar_pkg::ST_EVAL: begin
        done_d        = 1'b1;
        res_d         = '0;
        res_d.outcome = htar_pkg::OUT_NONE;
        if (req_q.kind == htar_pkg::KIND_PROBE) begin
          if (is_match) begin
            res_d.hit         = 1'b1;
            res_d.entry_score = rd_pay_q.score;
            res_d.entry_depth = rd_pay_q.depth;
            res_d.entry_flag  = rd_pay_q.flag;
            res_d.entry_move  = rd_pay_q.move;
            res_d.entry_age   = rd_pay_q.age;
          end
        end else if (is_empty) begin
          mem_we        = 1'b1;
          res_d.outcome = htar_pkg::OUT_EMPTY;
        end else if (is_match) begin
          mem_we        = 1'b1;
          res_d.outcome = htar_pkg::OUT_REFRESH;
          wr_pay        = rd_pay_q;
          if (req_q.search_depth >= rd_pay_q.depth ||
              req_q.bound_flag == 2'(htar_pkg::FLAG_EXACT)) begin
            wr_pay.score = req_q.score;
            wr_pay.depth = req_q.search_depth;
            wr_pay.flag  = req_q.bound_flag;
          end
          if (req_q.best_move != '0) wr_pay.move = req_q.best_move;
          wr_pay.age = age_q;
        end else if (18'(req_q.search_depth) >= worth) begin
          mem_we        = 1'b1;
          res_d.outcome = (rd_pay_q.age != age_q) ? htar_pkg::OUT_STALE
                                                  : htar_pkg::OUT_DEPTH;
        end else begin
          res_d.outcome = htar_pkg::OUT_REJECT;
        end
      end
      default: begin
      end
    endcase
  end

  // slot memory: one write port, registered read at the computed index
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      key_mem[wr_addr] <= wr_key;
      pay_mem[wr_addr] <= wr_pay;
    end
    rd_key_q <= key_mem[rem[AW-1:0]];
    rd_pay_q <= pay_mem[rem[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= htar_pkg::ST_CLEAR;
      done_q    <= 1'b0;
      clr_cmd_q <= 1'b0;
      clr_cnt_q <= '0;
      age_q     <= 8'd0;
      entries_q <= htar_pkg::CfgW'(65536);
      weight_q  <= 8'd2;
    end else begin
      state_q   <= state_d;
      done_q    <= done_d;
      clr_cmd_q <= clr_cmd_d;
      clr_cnt_q <= clr_cnt_d;
      age_q     <= age_d;
      if (cfg_we_i) begin
        unique case (htar_pkg::reg_idx_e'(cfg_idx_i))
          htar_pkg::REG_ENTRIES: entries_q <= cfg_data_i;
          htar_pkg::REG_WEIGHT:  weight_q  <= cfg_data_i[7:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    res_q  <= res_d;
    prod_q <= prod_d;
  end

  assign busy   = (state_q != htar_pkg::ST_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> state_q == htar_pkg::ST_IDLE)
    else $error("result strobe outside idle");

  a_hit_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.hit) |-> res_o.outcome == htar_pkg::OUT_NONE)
    else $error("hit on a non-probe result");

  a_div_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> state_q == htar_pkg::ST_DIV)
    else $error("lookup did not enter divide");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == htar_pkg::ST_DIV)
    else $error("remainder done outside divide");

endmodule
`default_nettype wire

/* test/table_result_checker.sv */
// Checker: watches requests, register writes and results, predicts and compares.
`timescale 1ns / 1ps
module table_result_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      busy_i,
  input  htar_pkg::req_t            req_i,
  input  logic                      done_i,
  input  htar_pkg::res_t            res_i,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [htar_pkg::CfgW-1:0] cfg_data_i,
  output int                        fail_count_o,
  output int                        pending_o
);

  localparam longint unsigned SLOTS = 65536;

  logic [63:0]     slot_key [int unsigned];
  htar_pkg::slot_t slot_data [int unsigned];
  logic [7:0]      table_age;
  logic [16:0]     entries;
  logic [7:0]      weight;
  htar_pkg::res_t  expected_results[$];
  int              fails;

  function automatic htar_pkg::res_t apply_command(htar_pkg::req_t r);
    htar_pkg::res_t  o;
    longint unsigned n;
    int unsigned     idx;
    logic [63:0]     k;
    htar_pkg::slot_t s;
    logic [7:0]      diff;
    int              worth;
    o = '0;
    o.outcome = htar_pkg::OUT_NONE;
    case (r.kind) inside
      htar_pkg::KIND_STORE, htar_pkg::KIND_PROBE: begin
        n = entries;
        if (n == 0) n = 1;
        if (n > SLOTS) n = SLOTS;
        idx = int'(r.key % n);
        k = slot_key.exists(idx) ? slot_key[idx] : 64'd0;
        s = slot_data.exists(idx) ? slot_data[idx] : '0;
        if (r.kind == htar_pkg::KIND_PROBE) begin
          if (k == r.key) begin
            o.hit         = 1'b1;
            o.entry_score = s.score;
            o.entry_depth = s.depth;
            o.entry_flag  = s.flag;
            o.entry_move  = s.move;
            o.entry_age   = s.age;
          end
        end else begin
          if (k == 64'd0) begin
            slot_key[idx] = r.key;
            s = '{r.score, r.search_depth, r.bound_flag, r.best_move, table_age};
            o.outcome = htar_pkg::OUT_EMPTY;
          end else if (k == r.key) begin
            if (r.search_depth >= s.depth || r.bound_flag == htar_pkg::FLAG_EXACT) begin
              s.score = r.score;
              s.depth = r.search_depth;
              s.flag  = r.bound_flag;
            end
            if (r.best_move != 16'd0) s.move = r.best_move;
            s.age = table_age;
            o.outcome = htar_pkg::OUT_REFRESH;
          end else begin
            // older entries lose worth per generation; age distance wraps at 8 bits
            diff = table_age - s.age;
            worth = int'(s.depth) - int'(weight) * int'(diff);
            if (int'(r.search_depth) >= worth) begin
              o.outcome = (s.age != table_age) ? htar_pkg::OUT_STALE : htar_pkg::OUT_DEPTH;
              slot_key[idx] = r.key;
              s = '{r.score, r.search_depth, r.bound_flag, r.best_move, table_age};
            end else begin
              o.outcome = htar_pkg::OUT_REJECT;
            end
          end
          slot_data[idx] = s;
        end
      end
      htar_pkg::KIND_SEARCH: table_age = table_age + 8'd1;
      default: begin
        slot_key.delete();
        slot_data.delete();
        table_age = '0;
      end
    endcase
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    htar_pkg::res_t exp_res;
    if (!rst_ni) begin
      slot_key.delete();
      slot_data.delete();
      expected_results.delete();
      table_age = '0;
      entries   = 17'd65536;
      weight    = 8'd2;
      fails     = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (done_i) begin
        if (expected_results.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result %p", res_i);
        end else begin
          exp_res = expected_results.pop_front();
          if (res_i.hit !== exp_res.hit || res_i.entry_score !== exp_res.entry_score ||
              res_i.entry_depth !== exp_res.entry_depth ||
              res_i.entry_flag !== exp_res.entry_flag ||
              res_i.entry_move !== exp_res.entry_move ||
              res_i.entry_age !== exp_res.entry_age ||
              res_i.outcome !== exp_res.outcome) begin
            fails++;
            if (fails <= 10) $display("mismatch: expected %p got %p", exp_res, res_i);
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == htar_pkg::REG_ENTRIES) entries = cfg_data_i;
        else weight = cfg_data_i[7:0];
      end
      if (start_i && !busy_i) expected_results.push_back(apply_command(req_i));
      fail_count_o <= fails;
      pending_o    <= expected_results.size();
    end
  end

endmodule

/* test/tb_hashed_table_with_age_replacement.sv */
// Testbench top: drives requests and register writes, reports the verdict.
`timescale 1ns / 1ps
module tb_hashed_table_with_age_replacement;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  htar_pkg::req_t            req_i = '0;
  logic                      done_o;
  htar_pkg::res_t            res_o;
  logic                      cfg_we_i = 1'b0;
  logic                      cfg_idx_i = 1'b0;
  logic [htar_pkg::CfgW-1:0] cfg_data_i = '0;
  int                        fail_count;
  int                        pending;
  int                        sent;
  int                        idle_pct;
  int                        clears_left;
  logic [63:0]               key_pool [8];

  always #1 clk_i = ~clk_i;

  hashed_table_with_age_replacement dut (.*);

  table_result_checker checker_i (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .req_i, .done_i(done_o),
    .res_i(res_o), .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    #8_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic htar_pkg::req_t make_req(htar_pkg::kind_e k, logic [63:0] key,
                                              logic [15:0] sc, logic [15:0] dp,
                                              logic [1:0] fl, logic [15:0] mv);
    htar_pkg::req_t r;
    r = '{k, key, sc, dp, fl, mv};
    return r;
  endfunction

  // holds start high until the request is taken; may then drop start for a random idle spell
  task automatic send(htar_pkg::req_t r);
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sent++;
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || busy) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_reg(htar_pkg::reg_idx_e idx, logic [htar_pkg::CfgW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic htar_pkg::req_t random_req();
    htar_pkg::req_t r;
    logic [63:0]    key;
    int             roll;
    roll = $urandom_range(0, 99);
    key = {$urandom, $urandom};
    if ($urandom_range(0, 2) == 0) key[15:0] = 16'($urandom_range(0, 3));
    if ($urandom_range(0, 9) < 4) key = key_pool[3'($urandom_range(0, 7))];
    if ($urandom_range(0, 49) == 0) key = '0;
    r.key = key;
    r.score = 16'($urandom);
    r.search_depth = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
    r.bound_flag = 2'($urandom_range(0, 3));
    r.best_move = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
    if (roll < 50) r.kind = htar_pkg::KIND_STORE;
    else if (roll < 86) r.kind = htar_pkg::KIND_PROBE;
    else r.kind = htar_pkg::KIND_SEARCH;
    if (clears_left > 0 && $urandom_range(0, 149) == 0) begin
      r.kind = htar_pkg::KIND_CLEAR;
      clears_left--;
    end
    return r;
  endfunction

  initial begin
    logic [16:0] ent_set [6];
    sent = 0;
    idle_pct = 33;
    clears_left = 3;
    ent_set = '{17'd0, 17'd1, 17'd7, 17'd131071, 17'd16, 17'd65536};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);

    // directed: default registers, age 0
    send(make_req(htar_pkg::KIND_STORE, 64'd0, 16'h7fff, 16'h8000, 2'd3, 16'hffff));
    send(make_req(htar_pkg::KIND_PROBE, 64'd0, '0, '0, '0, '0));
    send(make_req(htar_pkg::KIND_STORE, 64'd5, 16'h8000, 16'd10, 2'd1, 16'd7));
    send(make_req(htar_pkg::KIND_STORE, 64'd5, 16'd1, 16'd3, 2'd2, 16'd0));   // shallower, kept
    send(make_req(htar_pkg::KIND_STORE, 64'd5, 16'd2, 16'd3, 2'd0, 16'd9));   // exact wins
    send(make_req(htar_pkg::KIND_PROBE, 64'd5, '0, '0, '0, '0));
    send(make_req(htar_pkg::KIND_STORE, 64'd65541, 16'd4, 16'd2, 2'd1, 16'd1)); // rejected
    send(make_req(htar_pkg::KIND_SEARCH, '0, '0, '0, '0, '0));
    send(make_req(htar_pkg::KIND_STORE, 64'd65541, 16'd4, 16'd2, 2'd1, 16'd1)); // stale evict
    send(make_req(htar_pkg::KIND_STORE, 64'd131077, 16'd5, 16'h7fff, 2'd2, 16'd2)); // depth evict
    send(make_req(htar_pkg::KIND_PROBE, 64'd65541, '0, '0, '0, '0));
    send(make_req(htar_pkg::KIND_PROBE, 64'd131077, '0, '0, '0, '0));
    send(make_req(htar_pkg::KIND_STORE, '1, 16'hffff, 16'h7fff, 2'd2, 16'h8000));
    send(make_req(htar_pkg::KIND_PROBE, '1, '0, '0, '0, '0));
    send(make_req(htar_pkg::KIND_CLEAR, '0, '0, '0, '0, '0));
    send(make_req(htar_pkg::KIND_PROBE, '1, '0, '0, '0, '0));
    send(make_req(htar_pkg::KIND_STORE, 64'd9, 16'd3, 16'd100, 2'd1, 16'd3));
    // age wraps past 255 with an old entry still in the table
    repeat (260) send(make_req(htar_pkg::KIND_SEARCH, '0, '0, '0, '0, '0));
    send(make_req(htar_pkg::KIND_PROBE, 64'd9, '0, '0, '0, '0));
    send(make_req(htar_pkg::KIND_STORE, 64'd65545, 16'd1, 16'd0, 2'd2, 16'd4));

    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      write_reg(htar_pkg::REG_ENTRIES, ent_set[ph]);
      write_reg(htar_pkg::REG_WEIGHT,
                (ph == 0) ? 17'd0 : (ph == 1) ? 17'd255 : 17'($urandom_range(0, 255)));
      foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
      for (int i = 0; i < 54; i++) begin
        if (sent > 380) idle_pct = 51;
        if (sent > 490) idle_pct = 0;
        send(random_req());
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/htar_pkg.sv
hdl/htar_mod.sv
hdl/hashed_table_with_age_replacement.sv
test/table_result_checker.sv
test/tb_hashed_table_with_age_replacement.sv
